/* sv/mvd_pkg.sv */
package mvd_pkg;

	localparam int HIST_ENTRIES = 16;
	localparam int HIST_IW = $clog2(HIST_ENTRIES);
	localparam int NUM_AXES = 3;
	localparam int CFG_AW = 5;
	localparam logic [15:0] LEARN_MARGIN = 16'd200;
	localparam logic [15:0] NO_TRACKING = 16'hFFFF;

	typedef enum logic [CFG_AW-3:0] {
		REG_GAIN_X    = 3'd0,
		REG_GAIN_Y    = 3'd1,
		REG_GAIN_Z    = 3'd2,
		REG_ENTER_THR = 3'd3,
		REG_EXIT_THR  = 3'd4,
		REG_EXIT_TIME = 3'd5,
		REG_BG_WINDOW = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LANE,
		ST_MERGE,
		ST_HIST,
		ST_MODE,
		ST_DONE
	} state_t;

	// result of one lane
	typedef struct packed {
		logic signed [10:0] diff;
		logic [15:0]        exc;
	} lane_res_t;

endpackage

/* sv/mvd_if.sv */
interface mvd_in_if;
	import mvd_pkg::*;
	logic        valid;
	logic        ready;
	logic        polarity;
	logic [47:0] samples_x;
	logic [47:0] samples_y;
	logic [47:0] samples_z;
	logic        start_learning;
	logic        clear_peaks;
	modport source (output valid, polarity, samples_x, samples_y, samples_z,
		start_learning, clear_peaks, input ready);
	modport sink (input valid, polarity, samples_x, samples_y, samples_z,
		start_learning, clear_peaks, output ready);
endinterface

interface mvd_out_if;
	logic        valid;
	logic        ready;
	logic        detected;
	logic [15:0] total_excitation;
	logic [15:0] total_peak;
	logic [15:0] peak_x;
	logic [15:0] peak_y;
	logic [15:0] peak_z;
	logic        learning_active;
	modport source (output valid, detected, total_excitation, total_peak, peak_x, peak_y,
		peak_z, learning_active, input ready);
	modport sink (input valid, detected, total_excitation, total_peak, peak_x, peak_y,
		peak_z, learning_active, output ready);
endinterface

/* sv/mvd_lane.sv */
module mvd_lane
	import mvd_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [9:0]        set_rd,
	input  logic [9:0]        reset_rd,
	input  logic signed [11:0] bg,
	input  logic [15:0]       gain,
	output lane_res_t         res
);

	logic signed [12:0] dev;
	logic [12:0]        mag;
	logic [28:0]        prod;
	logic signed [10:0] d;

	// differential and deviation from background
	always_comb begin
		d = $signed({1'b0, set_rd}) - $signed({1'b0, reset_rd});
		dev = 13'(d) - 13'(bg);
		mag = dev[12] ? 13'(-dev) : dev;
		prod = 29'(mag) * 29'(gain);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.diff <= d;
			res.exc <= prod[15:0];
		end
	end

endmodule

/* sv/mvd_hist.sv */
module mvd_hist
	import mvd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              ins,
	input  logic signed [9:0] ins_v,
	input  logic [HIST_IW-1:0] idx,
	output logic              hit,
	output logic              empty,
	output logic signed [9:0] rd_v,
	output logic [15:0]       rd_c
);

	logic signed [9:0] val_q [HIST_ENTRIES];
	logic [15:0]       cnt_q [HIST_ENTRIES];

	// one entry looked at per cycle
	always_comb begin
		rd_v = val_q[idx];
		rd_c = cnt_q[idx];
		hit = (rd_v == ins_v);
		empty = (rd_v == 10'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_ENTRIES; i++) begin
				val_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < HIST_ENTRIES; i++) begin
				val_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (ins) begin
			if (hit) cnt_q[idx] <= cnt_q[idx] + 16'd1;
			else val_q[idx] <= ins_v;
		end
	end

endmodule

/* sv/magnetic_vehicle_detector_core.sv */
// steps: a reset reading goes straight to the result step; a set reading passes the
// lane, merge, a histogram walk (search or scan, one entry a cycle) and the result
// throughput: one item at a time
// the next item may enter while a result beat waits; it holds in its last step
// until the result register frees
// reset: arst_n clears control state and histogram at once; config gets defaults
module magnetic_vehicle_detector_core
	import mvd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mvd_in_if.sink            in_ch,
	mvd_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [15:0] gain_q [NUM_AXES];
	logic [15:0] enter_q, exitthr_q, exittime_q, window_q;

	logic [9:0]        set_q [NUM_AXES];
	logic [9:0]        rst_q [NUM_AXES];
	logic signed [10:0] diff_q [NUM_AXES];
	logic signed [11:0] bg_q [NUM_AXES];
	logic [15:0]       apeak_q [NUM_AXES];
	logic [15:0]       speak_q, total_q, exitcnt_q, wincnt_q, best_q;
	logic [1:0]        axis_q;
	logic              det_q, learn_q, seen_q;
	logic signed [9:0] mode_q;
	logic [HIST_IW-1:0] idx_q;
	state_t            st_q, st_d;

	logic              ovalid_q;
	logic              o_det_q, o_learn_q;
	logic [15:0]       o_tot_q, o_sp_q, o_px_q, o_py_q, o_pz_q;

	lane_res_t         lres [NUM_AXES];
	logic              lane_en;
	logic              wr;
	logic [2:0]        waddr;

	// configuration port
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign waddr = paddr[CFG_AW-1:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= 16'd1; gain_q[1] <= 16'd1; gain_q[2] <= 16'd1;
			enter_q <= 16'd100; exitthr_q <= 16'd50; exittime_q <= 16'd10;
			window_q <= 16'd1000;
		end else if (wr) begin
			case (waddr)
				REG_GAIN_X:    gain_q[0] <= pwdata[15:0];
				REG_GAIN_Y:    gain_q[1] <= pwdata[15:0];
				REG_GAIN_Z:    gain_q[2] <= pwdata[15:0];
				REG_ENTER_THR: enter_q <= pwdata[15:0];
				REG_EXIT_THR:  exitthr_q <= pwdata[15:0];
				REG_EXIT_TIME: exittime_q <= pwdata[15:0];
				REG_BG_WINDOW: window_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = '0;
		case (waddr)
			REG_GAIN_X:    prdata = {16'd0, gain_q[0]};
			REG_GAIN_Y:    prdata = {16'd0, gain_q[1]};
			REG_GAIN_Z:    prdata = {16'd0, gain_q[2]};
			REG_ENTER_THR: prdata = {16'd0, enter_q};
			REG_EXIT_THR:  prdata = {16'd0, exitthr_q};
			REG_EXIT_TIME: prdata = {16'd0, exittime_q};
			REG_BG_WINDOW: prdata = {16'd0, window_q};
			default:       prdata = '0;
		endcase
	end

	// four-sample sums over 16 (a quarter of the four-sample average)
	function automatic logic [9:0] avg4(input logic [47:0] p);
		logic [13:0] s;
		s = 14'(p[11:0]) + 14'(p[23:12]) + 14'(p[35:24]) + 14'(p[47:36]);
		return s[13:4];
	endfunction

	logic in_fire, out_fire, res_load;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	// result register takes a new beat once the old one is gone
	assign res_load = (st_q == ST_DONE) && (!ovalid_q || out_fire);

	// lanes
	assign lane_en = (st_q == ST_LANE);
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		mvd_lane u_lane (.clk, .en(lane_en), .set_rd(set_q[a]), .reset_rd(rst_q[a]),
			.bg(bg_q[a]), .gain(gain_q[a]), .res(lres[a]));
	end

	// histogram
	logic              h_clr, h_ins, h_hit, h_empty;
	logic signed [9:0] h_v, h_rv, ins_v;
	logic [15:0]       h_rc;
	logic signed [10:0] dsel;
	logic [15:0]       learn_time;
	logic              walking;
	assign learn_time = (window_q >= LEARN_MARGIN) ? window_q - LEARN_MARGIN : 16'd0;
	assign dsel = diff_q[axis_q];
	assign ins_v = 10'(dsel / 11'sd2);
	assign walking = (st_q == ST_HIST);
	mvd_hist u_hist (.clk, .arst_n, .clr(h_clr), .ins(h_ins), .ins_v(ins_v),
		.idx(idx_q), .hit(h_hit), .empty(h_empty), .rd_v(h_rv), .rd_c(h_rc));
	assign h_v = h_rv;

	logic last_idx;
	assign last_idx = (idx_q == HIST_IW'(HIST_ENTRIES - 1));
	assign h_ins = walking && (h_hit || h_empty);
	logic merge_learn_start;
	assign merge_learn_start = (st_q == ST_MERGE) && learn_q && !seen_q;
	assign h_clr = merge_learn_start || (walking && !h_hit && !h_empty && last_idx)
		|| (st_q == ST_MODE && last_idx);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_fire) st_d = in_ch.polarity ? ST_DONE : ST_LANE;
			ST_LANE: st_d = ST_MERGE;
			ST_MERGE: begin
				if (((merge_learn_start ? learn_time : wincnt_q)) < window_q) st_d = ST_HIST;
				else st_d = ST_MODE;
			end
			ST_HIST: if (h_hit || h_empty || last_idx) st_d = ST_DONE;
			ST_MODE: if (last_idx) st_d = ST_DONE;
			ST_DONE: if (res_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// datapath and control
	logic [15:0] tot_c, ec_inc;
	logic [1:0]  nax;
	always_comb begin
		tot_c = lres[0].exc + lres[1].exc + lres[2].exc;
		ec_inc = exitcnt_q + 16'd1;
		nax = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int a = 0; a < NUM_AXES; a++) begin
				set_q[a] <= '0; rst_q[a] <= '0; diff_q[a] <= '0; bg_q[a] <= '0;
				apeak_q[a] <= '0;
			end
			speak_q <= '0; total_q <= '0; exitcnt_q <= '0; wincnt_q <= '0;
			best_q <= '0; mode_q <= '0; idx_q <= '0; axis_q <= '0;
			det_q <= 1'b0; learn_q <= 1'b0; seen_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_load) ovalid_q <= 1'b1;
			else if (out_fire) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (in_fire) begin
					if (in_ch.start_learning) learn_q <= 1'b1;
					if (in_ch.clear_peaks) begin
						speak_q <= '0;
						for (int a = 0; a < NUM_AXES; a++) apeak_q[a] <= '0;
					end
					if (in_ch.polarity) begin
						rst_q[0] <= avg4(in_ch.samples_x);
						rst_q[1] <= avg4(in_ch.samples_y);
						rst_q[2] <= avg4(in_ch.samples_z);
					end else begin
						set_q[0] <= avg4(in_ch.samples_x);
						set_q[1] <= avg4(in_ch.samples_y);
						set_q[2] <= avg4(in_ch.samples_z);
					end
				end
				ST_MERGE: begin
					for (int a = 0; a < NUM_AXES; a++) begin
						diff_q[a] <= lres[a].diff;
						if (lres[a].exc > apeak_q[a]) apeak_q[a] <= lres[a].exc;
					end
					total_q <= tot_c;
					if (tot_c > speak_q) speak_q <= tot_c;
					if (det_q) begin
						if (tot_c < exitthr_q) begin
							if (ec_inc >= exittime_q) begin
								det_q <= 1'b0; exitcnt_q <= '0;
							end else exitcnt_q <= ec_inc;
						end else exitcnt_q <= '0;
					end else if (tot_c > enter_q) det_q <= 1'b1;
					if (merge_learn_start) begin
						wincnt_q <= learn_time; axis_q <= '0; seen_q <= 1'b1;
					end else if (axis_q > 2'd2) axis_q <= '0;
					idx_q <= '0; best_q <= '0; mode_q <= '0;
				end
				ST_HIST: begin
					if (h_hit || h_empty) wincnt_q <= wincnt_q + 16'd1;
					else if (last_idx) wincnt_q <= '0;
					idx_q <= idx_q + HIST_IW'(1);
				end
				ST_MODE: begin
					idx_q <= idx_q + HIST_IW'(1);
					if (h_rc > best_q) begin
						best_q <= h_rc; mode_q <= h_v;
					end
					if (last_idx) begin
						if (window_q != NO_TRACKING || learn_q) begin
							// background is twice the mode, sign kept
							if (h_rc > best_q) bg_q[axis_q] <= {h_v[9], h_v, 1'b0};
							else bg_q[axis_q] <= {mode_q[9], mode_q, 1'b0};
						end
						wincnt_q <= learn_q ? learn_time : 16'd0;
						axis_q <= nax;
						if (axis_q == 2'd2) begin
							learn_q <= 1'b0; seen_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			o_det_q <= det_q; o_tot_q <= total_q; o_sp_q <= speak_q;
			o_px_q <= apeak_q[0]; o_py_q <= apeak_q[1]; o_pz_q <= apeak_q[2];
			o_learn_q <= learn_q;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.detected = o_det_q;
	assign out_ch.total_excitation = o_tot_q;
	assign out_ch.total_peak = o_sp_q;
	assign out_ch.peak_x = o_px_q;
	assign out_ch.peak_y = o_py_q;
	assign out_ch.peak_z = o_pz_q;
	assign out_ch.learning_active = o_learn_q;

endmodule

/* sv/mvd_checker.sv */
module mvd_checker
	import mvd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] total_peak,
	input logic [15:0] total_excitation
);

	// one item in flight: input closes right after a beat is taken
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("input open after beat");

	// stalled result keeps its payload
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(total_peak) && $stable(total_excitation)))
		else $error("result changed while stalled");

	// peak never below shown total, unless the peak is zero
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_peak >= total_excitation || total_peak == 16'd0)
		else $error("peak below total");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind magnetic_vehicle_detector_core mvd_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .total_peak(out_ch.total_peak),
	.total_excitation(out_ch.total_excitation));
